/* hw/rtl/lcp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared widths, constants and types of the line sensor centroid block.
// ----------------------------------------------------------------------------
package lcp_pkg;

   localparam int WEIGHT_NUM = 8;
   localparam int WEIGHT_W   = 8;
   localparam int MASK_W     = 8;
   localparam int IDX_W      = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int PROD_W     = WEIGHT_W + IDX_W;
   localparam int WSUM_W     = WEIGHT_W + IDX_W;
   localparam int ISUM_W     = 13;
   localparam int DEN_W      = 14;
   localparam int PART_W     = DEN_W + 1;
   localparam int Q_FRAC     = 14;
   localparam int MAG_W      = Q_FRAC + 1;
   localparam int POS_W      = 16;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd16;

   typedef struct packed {
      logic lost;
      logic neg;
   } ctrl_type;

endpackage

/* hw/rtl/line_sensor_centroid_position.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_centroid_position
// Weighted centroid of an inverted line-sensor mask, normalized to Q1.14
// about the array center and shaped to sign * |pos|^SHAPING_POWER.
// Pipeline from req beat to rsp beat: lane stage, merge stage, 15 divider
// stages, SHAPING_POWER-1 multiply stages and the output stage.
// Throughput: one beat per cycle; each pipeline stage holds one item and
// stalls only when the stage after it is full and stalled.
// Reset clears all pipeline valid bits and sets every weight to 16.
// ----------------------------------------------------------------------------
module line_sensor_centroid_position import lcp_pkg::*; #(
   parameter int SENSOR_NUMBER = 8,
   parameter int SHAPING_POWER = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [MASK_W-1:0]    req_tdata,   // [7:0] sensor_mask
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [POS_W-1:0]     rsp_tdata,   // [15:0] line_position
   output logic                 rsp_tuser,   // [0] line_lost
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WEIGHT_W-1:0]  csr_data
);

   localparam int NUM_MUL  = SHAPING_POWER - 1;
   localparam int ST_DIV   = 2;
   localparam int ST_MUL   = ST_DIV + MAG_W;
   localparam int NST      = ST_MUL + NUM_MUL + 1;

   // weights
   logic [WEIGHT_W-1:0] weight_ff [WEIGHT_NUM];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WEIGHT_NUM; i++) begin
            weight_ff[i] <= WEIGHT_RESET;
         end
      end else if (csr_valid && (csr_index < CSR_IDX_W'(WEIGHT_NUM))) begin
         weight_ff[csr_index[IDX_W-1:0]] <= csr_data;
      end
   end

   // stage valid chain
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] valid_in;
   logic [NST-1:0] stage_rdy;

   always_comb begin
      stage_rdy[NST-1] = !valid_ff[NST-1] || rsp_tready;
      for (int s = NST - 2; s >= 0; s--) begin
         stage_rdy[s] = !valid_ff[s] || stage_rdy[s+1];
      end
      valid_in[0] = req_tvalid;
      for (int s = 1; s < NST; s++) begin
         valid_in[s] = valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NST; s++) begin
            if (stage_rdy[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   assign req_tready = stage_rdy[0];
   assign rsp_tvalid = valid_ff[NST-1];

   // lanes
   logic [WEIGHT_W-1:0] lane_wgt  [SENSOR_NUMBER];
   logic [PROD_W-1:0]   lane_prod [SENSOR_NUMBER];

   for (genvar i = 0; i < SENSOR_NUMBER; i++) begin : g_lane
      lcp_lane #(.IDX(i)) u_lane (
         .clock   (clock),
         .en      (stage_rdy[0]),
         .dark    (!req_tdata[i]),
         .weight  (weight_ff[i]),
         .wgt_ff  (lane_wgt[i]),
         .prod_ff (lane_prod[i])
      );
   end

   // merge
   logic [PART_W-1:0] dpart [MAG_W+1];
   logic [MAG_W-1:0]  dquo  [MAG_W+1];
   logic [DEN_W-1:0]  dden  [MAG_W+1];
   ctrl_type          dctrl [MAG_W+1];

   lcp_merge #(.SENSOR_NUMBER(SENSOR_NUMBER)) u_merge (
      .clock     (clock),
      .en        (stage_rdy[1]),
      .lane_wgt  (lane_wgt),
      .lane_prod (lane_prod),
      .num_ff    (dpart[0]),
      .den_ff    (dden[0]),
      .ctrl_ff   (dctrl[0])
   );

   assign dquo[0] = '0;

   // divider
   for (genvar k = 0; k < MAG_W; k++) begin : g_div
      lcp_div_stage u_div (
         .clock   (clock),
         .en      (stage_rdy[ST_DIV+k]),
         .part    (dpart[k]),
         .quo     (dquo[k]),
         .den     (dden[k]),
         .ctrl    (dctrl[k]),
         .part_ff (dpart[k+1]),
         .quo_ff  (dquo[k+1]),
         .den_ff  (dden[k+1]),
         .ctrl_ff (dctrl[k+1])
      );
   end

   // shaping
   logic [MAG_W-1:0] mmag  [NUM_MUL+1];
   logic [MAG_W-1:0] mlin  [NUM_MUL+1];
   ctrl_type         mctrl [NUM_MUL+1];

   assign mmag[0]  = dquo[MAG_W];
   assign mlin[0]  = dquo[MAG_W];
   assign mctrl[0] = dctrl[MAG_W];

   for (genvar m = 0; m < NUM_MUL; m++) begin : g_mul
      lcp_mul_stage u_mul (
         .clock   (clock),
         .en      (stage_rdy[ST_MUL+m]),
         .mag     (mmag[m]),
         .lin     (mlin[m]),
         .ctrl    (mctrl[m]),
         .mag_ff  (mmag[m+1]),
         .lin_ff  (mlin[m+1]),
         .ctrl_ff (mctrl[m+1])
      );
   end

   // output register
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             lost_ff;
   logic [POS_W-1:0] mag_ext;

   always_comb begin
      mag_ext = POS_W'(mmag[NUM_MUL]);
      if (mctrl[NUM_MUL].lost) begin
         pos_in = '0;
      end else if (mctrl[NUM_MUL].neg) begin
         pos_in = POS_W'(-mag_ext);
      end else begin
         pos_in = mag_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[NST-1]) begin
         pos_ff  <= pos_in;
         lost_ff <= mctrl[NUM_MUL].lost;
      end
   end

   assign rsp_tdata = pos_ff;
   assign rsp_tuser = lost_ff;

   // checks
   a_lost_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("line lost with nonzero position");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata) <= 16'sd16384) &&
                     ($signed(rsp_tdata) >= -16'sd16384))
      else $error("position out of Q1.14 range");

   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted beat missing from lane stage");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NST-2] && rsp_tvalid && !rsp_tready |=> valid_ff[NST-2])
      else $error("item dropped behind stalled output");

endmodule

/* hw/rtl/lcp_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_lane
// One sensor lane: masked weight and index-weighted product, registered.
// ----------------------------------------------------------------------------
module lcp_lane import lcp_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic                clock,
   input  logic                en,
   input  logic                dark,
   input  logic [WEIGHT_W-1:0] weight,
   output logic [WEIGHT_W-1:0] wgt_ff,
   output logic [PROD_W-1:0]   prod_ff
);

   localparam logic [IDX_W-1:0] LANE_IDX = IDX_W'(IDX);

   logic [WEIGHT_W-1:0] wgt_in;
   logic [PROD_W-1:0]   prod_in;

   always_comb begin
      wgt_in  = dark ? weight : '0;
      prod_in = PROD_W'(LANE_IDX) * PROD_W'(wgt_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wgt_ff  <= wgt_in;
         prod_ff <= prod_in;
      end
   end

endmodule

/* hw/rtl/lcp_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_merge
// Sums the lane results and forms the numerator magnitude and sign, the denominator and the line-lost flag.
// ----------------------------------------------------------------------------
module lcp_merge import lcp_pkg::*; #(
   parameter int SENSOR_NUMBER = 8
) (
   input  logic                clock,
   input  logic                en,
   input  logic [WEIGHT_W-1:0] lane_wgt  [SENSOR_NUMBER],
   input  logic [PROD_W-1:0]   lane_prod [SENSOR_NUMBER],
   output logic [PART_W-1:0]   num_ff,
   output logic [DEN_W-1:0]    den_ff,
   output ctrl_type            ctrl_ff
);

   localparam logic [IDX_W-1:0] SPAN = IDX_W'(SENSOR_NUMBER - 1);

   logic [WSUM_W-1:0] wsum;
   logic [ISUM_W-1:0] isum;
   logic [DEN_W-1:0]  pos_term;
   logic [DEN_W-1:0]  neg_term;
   logic [PART_W-1:0] num_in;
   logic [DEN_W-1:0]  den_in;
   ctrl_type          ctrl_in;

   always_comb begin
      wsum = '0;
      isum = '0;
      for (int i = 0; i < SENSOR_NUMBER; i++) begin
         wsum = wsum + WSUM_W'(lane_wgt[i]);
         isum = isum + ISUM_W'(lane_prod[i]);
      end
      pos_term     = {isum, 1'b0};
      neg_term     = DEN_W'(SPAN) * DEN_W'(wsum);
      den_in       = neg_term;
      ctrl_in.lost = (wsum == '0);
      ctrl_in.neg  = (pos_term < neg_term);
      num_in       = ctrl_in.neg ? PART_W'(neg_term - pos_term)
                                 : PART_W'(pos_term - neg_term);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         ctrl_ff <= ctrl_in;
      end
   end

endmodule

/* hw/rtl/lcp_div_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_div_stage
// One restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module lcp_div_stage import lcp_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [PART_W-1:0] part,
   input  logic [MAG_W-1:0]  quo,
   input  logic [DEN_W-1:0]  den,
   input  ctrl_type          ctrl,
   output logic [PART_W-1:0] part_ff,
   output logic [MAG_W-1:0]  quo_ff,
   output logic [DEN_W-1:0]  den_ff,
   output ctrl_type          ctrl_ff
);

   logic              ge;
   logic [PART_W-1:0] rem;
   logic [PART_W-1:0] part_in;
   logic [MAG_W-1:0]  quo_in;

   always_comb begin
      ge      = (part >= PART_W'(den));
      rem     = ge ? (part - PART_W'(den)) : part;
      part_in = {rem[PART_W-2:0], 1'b0};
      quo_in  = {quo[MAG_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         part_ff <= part_in;
         quo_ff  <= quo_in;
         den_ff  <= den;
         ctrl_ff <= ctrl;
      end
   end

endmodule

/* hw/rtl/lcp_mul_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_mul_stage
// One shaping step: Q1.14 magnitude times the linear magnitude, truncated.
// ----------------------------------------------------------------------------
module lcp_mul_stage import lcp_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [MAG_W-1:0] mag,
   input  logic [MAG_W-1:0] lin,
   input  ctrl_type         ctrl,
   output logic [MAG_W-1:0] mag_ff,
   output logic [MAG_W-1:0] lin_ff,
   output ctrl_type         ctrl_ff
);

   logic [2*MAG_W-1:0] prod;
   logic [MAG_W-1:0]   mag_in;

   always_comb begin
      prod   = (2*MAG_W)'(mag) * (2*MAG_W)'(lin);
      mag_in = prod[Q_FRAC +: MAG_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         lin_ff  <= lin;
         ctrl_ff <= ctrl;
      end
   end

endmodule
